/* rtl/salc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// shared constants, codes and types of the set-associative lru cache model
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int unsigned DEF_MAX_SET_BITS = 6;
    localparam int unsigned DEF_MAX_WAYS     = 8;
    localparam int unsigned DEF_ADDR_WIDTH   = 48;
    localparam int unsigned DEF_COUNT_WIDTH  = 32;

    localparam int unsigned QUEUE_DEPTH = 2;

    // access modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_FETCH  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS_USED  = 2'd2;

    localparam logic [2:0] SET_BITS_RESET   = 3'd4;
    localparam logic [4:0] BLOCK_BITS_RESET = 5'd4;
    localparam logic [3:0] WAYS_USED_RESET  = 4'd1;

    // access outcomes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [4:0] block_bits;
        logic [3:0] ways_used;
    } cfg_t;

endpackage
`default_nettype wire

/* rtl/salc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salc_front
// accepts access beats, drops fetches, splits the address into set and tag
// ----------------------------------------------------------------------------
module salc_front
    import salc_pkg::*;
#(
    parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH,
    localparam int unsigned TAG_W       = ADDR_WIDTH - 2
) (
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [1:0]              mode,
    input  wire  [ADDR_WIDTH-1:0]   address,
    input  cfg_t                    cfg,
    input  wire                     q_ready,
    output logic                    q_push,
    output logic [MAX_SET_BITS-1:0] q_set,
    output logic [TAG_W-1:0]        q_tag,
    output logic                    q_modify
);

    logic [2:0]              s_eff;
    logic [4:0]              b_eff;
    logic [ADDR_WIDTH-1:0]   shifted;
    logic [ADDR_WIDTH-1:0]   tag_full;
    logic [MAX_SET_BITS-1:0] set_mask;

    always_comb begin
        if (cfg.set_bits == 3'd0) begin
            s_eff = 3'd1;
        end else if (32'(cfg.set_bits) > MAX_SET_BITS) begin
            s_eff = 3'(MAX_SET_BITS);
        end else begin
            s_eff = cfg.set_bits;
        end
        b_eff    = (cfg.block_bits == 5'd0) ? 5'd1 : cfg.block_bits;
        shifted  = address >> b_eff;
        set_mask = ~({MAX_SET_BITS{1'b1}} << s_eff);
        tag_full = shifted >> s_eff;
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && (mode != MODE_FETCH);
    assign q_set    = shifted[MAX_SET_BITS-1:0] & set_mask;
    assign q_tag    = tag_full[TAG_W-1:0];
    assign q_modify = (mode == MODE_MODIFY);

endmodule
`default_nettype wire

/* rtl/salc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salc_queue
// short queue of classified accesses between front and back
// ----------------------------------------------------------------------------
module salc_queue
    import salc_pkg::*;
#(
    parameter int unsigned WIDTH = 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  wire  [WIDTH-1:0] din,
    output logic             ready,
    input  wire              pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_next  = push ? PTR_W'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? PTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= din;
        end
    end

    assign ready = (cnt_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = slot_reg[rd_reg];

endmodule
`default_nettype wire

/* rtl/salc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salc_back
// reads a set row, does lookup and lru update, writes it back, keeps totals
// ----------------------------------------------------------------------------
module salc_back
    import salc_pkg::*;
#(
    parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
    parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH,
    parameter int unsigned COUNT_WIDTH  = DEF_COUNT_WIDTH,
    localparam int unsigned TAG_W       = ADDR_WIDTH - 2
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  cfg_t                   cfg,
    input  wire                    q_valid,
    output logic                   q_pop,
    input  wire [MAX_SET_BITS-1:0] q_set,
    input  wire [TAG_W-1:0]        q_tag,
    input  wire                    q_modify,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [1:0]             outcome,
    output logic                   second_hit,
    output logic [COUNT_WIDTH-1:0] hit_total,
    output logic [COUNT_WIDTH-1:0] miss_total,
    output logic [COUNT_WIDTH-1:0] evict_total
);

    localparam int unsigned RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned ENTRY_W  = 1 + RANK_W + TAG_W;
    localparam int unsigned ROW_W    = MAX_WAYS * ENTRY_W;
    localparam int unsigned NUM_ROWS = 1 << MAX_SET_BITS;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic {ST_IDLE, ST_LOOK} state_t;

    state_t                  state_reg;
    logic [ROW_W-1:0]        row_mem [NUM_ROWS];
    logic [ROW_W-1:0]        rd_row_reg;
    logic                    row_live_reg;
    logic [NUM_ROWS-1:0]     row_init_reg;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic                    modify_reg;
    logic                    m_valid_reg;
    logic [1:0]              outcome_reg;
    logic                    second_reg;
    logic [COUNT_WIDTH-1:0]  hit_reg, hit_next;
    logic [COUNT_WIDTH-1:0]  miss_reg, miss_next;
    logic [COUNT_WIDTH-1:0]  evict_reg, evict_next;

    logic                    done;
    logic [4:0]              ways_eff;
    logic [MAX_WAYS-1:0]     v;
    logic [RANK_W-1:0]       rk [MAX_WAYS];
    logic [TAG_W-1:0]        tg [MAX_WAYS];
    logic                    hit_found, empty_found;
    logic [WAY_W-1:0]        hit_way, empty_way, victim, pick;
    logic [RANK_W-1:0]       best;
    logic [RANK_W:0]         limit;
    logic [1:0]              outcome_next;
    logic [ROW_W-1:0]        row_next;
    logic [COUNT_WIDTH-1:0]  hit_a;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign done  = (state_reg == ST_LOOK) && (!m_valid_reg || m_ready);

    always_comb begin
        if (cfg.ways_used == 4'd0) begin
            ways_eff = 5'd1;
        end else if (32'(cfg.ways_used) > MAX_WAYS) begin
            ways_eff = 5'(MAX_WAYS);
        end else begin
            ways_eff = {1'b0, cfg.ways_used};
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            v[w]  = row_live_reg && rd_row_reg[w*ENTRY_W + ENTRY_W - 1];
            rk[w] = row_live_reg ? rd_row_reg[w*ENTRY_W + TAG_W +: RANK_W] : '0;
            tg[w] = rd_row_reg[w*ENTRY_W +: TAG_W];
        end
        // lowest matching way and lowest empty way
        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (5'(w) < ways_eff && v[w] && tg[w] == tag_reg) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (5'(w) < ways_eff && !v[w]) begin
                empty_found = 1'b1;
                empty_way   = WAY_W'(w);
            end
        end
        // oldest rank, highest way on ties
        best   = '0;
        victim = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (5'(w) < ways_eff && rk[w] >= best) begin
                best   = rk[w];
                victim = WAY_W'(w);
            end
        end
        if (hit_found) begin
            pick         = hit_way;
            limit        = {1'b0, rk[hit_way]};
            outcome_next = OUT_HIT;
        end else if (empty_found) begin
            pick         = empty_way;
            limit        = (RANK_W+1)'(MAX_WAYS);
            outcome_next = OUT_FILL;
        end else begin
            pick         = victim;
            limit        = {1'b0, best};
            outcome_next = OUT_EVICT;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == pick && 5'(w) < ways_eff) begin
                row_next[w*ENTRY_W +: ENTRY_W] = {1'b1, {RANK_W{1'b0}}, tag_reg};
            end else if (5'(w) < ways_eff && v[w] && {1'b0, rk[w]} < limit &&
                         rk[w] < RANK_W'(MAX_WAYS - 1)) begin
                row_next[w*ENTRY_W +: ENTRY_W] = {1'b1, RANK_W'(rk[w] + 1'b1), tg[w]};
            end else begin
                row_next[w*ENTRY_W +: ENTRY_W] = {v[w], rk[w], tg[w]};
            end
        end
        // totals, the second access of a modify always hits
        hit_a      = (outcome_next == OUT_HIT && hit_reg != CMAX) ?
                     COUNT_WIDTH'(hit_reg + 1'b1) : hit_reg;
        hit_next   = (modify_reg && hit_a != CMAX) ? COUNT_WIDTH'(hit_a + 1'b1) : hit_a;
        miss_next  = (outcome_next != OUT_HIT && miss_reg != CMAX) ?
                     COUNT_WIDTH'(miss_reg + 1'b1) : miss_reg;
        evict_next = (outcome_next == OUT_EVICT && evict_reg != CMAX) ?
                     COUNT_WIDTH'(evict_reg + 1'b1) : evict_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_init_reg <= '0;
            m_valid_reg  <= 1'b0;
            hit_reg      <= '0;
            miss_reg     <= '0;
            evict_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (q_pop) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (done) begin
                        state_reg             <= ST_IDLE;
                        row_init_reg[set_reg] <= 1'b1;
                        m_valid_reg           <= 1'b1;
                        hit_reg               <= hit_next;
                        miss_reg              <= miss_next;
                        evict_reg             <= evict_next;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // set row memory, read on pop, written back when the access completes
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_row_reg   <= row_mem[q_set];
            row_live_reg <= row_init_reg[q_set];
            set_reg      <= q_set;
            tag_reg      <= q_tag;
            modify_reg   <= q_modify;
        end
        if (done) begin
            row_mem[set_reg] <= row_next;
            outcome_reg      <= outcome_next;
            second_reg       <= modify_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign outcome     = outcome_reg;
    assign second_hit  = second_reg;
    assign hit_total   = hit_reg;
    assign miss_total  = miss_reg;
    assign evict_total = evict_reg;

endmodule
`default_nettype wire

/* rtl/set_assoc_lru_cache_model.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// tag-only set-associative cache with lru replacement and saturating totals
// ----------------------------------------------------------------------------
// Each access beat (mode in tuser, byte address in tdata) is classified by a
// front stage, queued two deep, and then handled by a back stage that reads
// the whole set row from a single-port row memory, compares all ways at once,
// updates recency ranks and writes the row back. A load, store or modify is a
// row read, then a compare and write-back once the result channel is free; it
// yields one result beat, an instruction fetch none. No new access enters the
// back stage until the last is written back. Rows never written since reset
// read as empty through one valid flag per row, so no clearing pass is needed.
// Configuration is to be written only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model
    import salc_pkg::*;
#(
    parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
    parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH,
    parameter int unsigned COUNT_WIDTH  = DEF_COUNT_WIDTH,
    localparam int unsigned IN_W        = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int unsigned OUT_W       = ((3 + 3 * COUNT_WIDTH + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    // configuration write port
    input  wire              cfg_wr_en,
    input  wire  [1:0]       cfg_index,
    input  wire  [4:0]       cfg_wr_data,
    // access beats
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire  [IN_W-1:0]  s_tdata,   // address
    input  wire  [1:0]       s_tuser,   // mode
    // result beats
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata    // first_outcome, second_hit, hit_total,
                                        // miss_total, evict_total
);

    localparam int unsigned TAG_W = ADDR_WIDTH - 2;
    localparam int unsigned JOB_W = MAX_SET_BITS + TAG_W + 1;

    cfg_t cfg_reg;

    // configuration registers, masked to their widths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_bits   <= SET_BITS_RESET;
            cfg_reg.block_bits <= BLOCK_BITS_RESET;
            cfg_reg.ways_used  <= WAYS_USED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SET_BITS:   cfg_reg.set_bits   <= cfg_wr_data[2:0];
                REG_BLOCK_BITS: cfg_reg.block_bits <= cfg_wr_data;
                REG_WAYS_USED:  cfg_reg.ways_used  <= cfg_wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    logic                    q_ready, q_push, q_valid, q_pop;
    logic [MAX_SET_BITS-1:0] f_set, b_set;
    logic [TAG_W-1:0]        f_tag, b_tag;
    logic                    f_modify, b_modify;
    logic [1:0]              outcome;
    logic                    second_hit;
    logic [COUNT_WIDTH-1:0]  hit_total, miss_total, evict_total;

    // front: accept, drop fetches, split address
    salc_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .address  (s_tdata[ADDR_WIDTH-1:0]),
        .cfg      (cfg_reg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_set    (f_set),
        .q_tag    (f_tag),
        .q_modify (f_modify)
    );

    // queue between the two halves
    salc_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({f_modify, f_tag, f_set}),
        .ready   (q_ready),
        .pop     (q_pop),
        .dout    ({b_modify, b_tag, b_set}),
        .valid   (q_valid)
    );

    // back: row lookup, lru update, totals and result register
    salc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_set       (b_set),
        .q_tag       (b_tag),
        .q_modify    (b_modify),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .outcome     (outcome),
        .second_hit  (second_hit),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total)
    );

    // result beat packing, zero filled to whole bytes
    assign m_tdata = OUT_W'({evict_total, miss_total, hit_total, second_hit, outcome});

endmodule
`default_nettype wire

/* rtl/salc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salc_checker
// port-level checks on the result channel of the cache model
// ----------------------------------------------------------------------------
module salc_checker
    import salc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
    localparam int unsigned OUT_W      = ((3 + 3 * COUNT_WIDTH + 7) / 8) * 8
) (
    input wire             aclk,
    input wire             aresetn,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata
);

    // no result beat straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // outcome code is hit, fill or evict
    a_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad outcome code");

    // a modify has hit at least once
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[COUNT_WIDTH+2:3] != '0)
        else $error("second hit without hit total");

endmodule

bind set_assoc_lru_cache_model salc_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_salc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
);
`default_nettype wire
